// ----- design/credit_weighted_round_robin_arbiter_assert.svh -----
// Assertion macros for the credit weighted round robin arbiter
`ifndef CREDIT_WEIGHTED_ROUND_ROBIN_ARBITER_ASSERT_SVH
`define CREDIT_WEIGHTED_ROUND_ROBIN_ARBITER_ASSERT_SVH

// holds at every edge out of reset
`define CWRR_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("cwrr invariant violated");

// consequent holds on the edge after the antecedent
`define CWRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cwrr sequence violated");

`endif

// ----- design/cwrr_pkg.sv -----
// Shared types and constants of the credit weighted round robin arbiter
`default_nettype none

package cwrr_pkg;

    localparam int NUM_QUEUES     = 5;
    localparam int WEIGHT_DIVISOR = 64;
    localparam int PEND_INPUTS    = 5;
    localparam int MASK_W         = 5;

    localparam int MODE_W   = 2;
    localparam int QID_W    = 3;
    localparam int STATUS_W = 2;
    localparam int PEND_W   = 16;
    localparam int CTOTAL_W = 13;

    localparam int PSUM_W     = PEND_W + 1;
    localparam int MAX_CREDIT = ((2 ** PEND_W) - 1 + WEIGHT_DIVISOR - 1) / WEIGHT_DIVISOR;
    localparam int CREDIT_W   = $clog2(MAX_CREDIT + 1);
    localparam int SUM_W      = $clog2(NUM_QUEUES * MAX_CREDIT + 1);
    localparam int IDX_W      = $clog2(NUM_QUEUES);
    localparam int LEN_W      = $clog2(NUM_QUEUES + 1);
    localparam int CTOTAL_MAX = (2 ** CTOTAL_W) - 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SELECT        = 2'd0,
        MODE_MARK_ACTIVE   = 2'd1,
        MODE_MARK_INACTIVE = 2'd2,
        MODE_UPDATE        = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NO_CREDIT   = 2'd1,
        ST_NO_ACTIVE   = 2'd2,
        ST_FRONT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RECOMP,
        S_DONE
    } t_state;

    typedef logic [PEND_INPUTS-1:0][PEND_W-1:0] t_pend_vec;

    typedef struct packed {
        logic             load;
        logic             exec;
        logic             recomp_step;
        logic [IDX_W-1:0] recomp_q;
        logic             out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_recomp;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/credit_weighted_round_robin_arbiter.sv -----
// Top level of the credit weighted round robin arbiter
//
//  beat     direction  handshake                 payload
//  event    in         i_in_valid / o_in_stall   i_mode, i_queue_id, i_all_blocked, i_pending_q0..4
//  result   out        o_out_valid / i_out_stall o_grant_valid .. o_active_mask
//
// One event at a time: accept, execute, then hand-off.
// A recompute walks the queues one per cycle in index order.
// The output register holds the last result; the next event is taken while it waits.
// A new result waits in the hand-off state while the output is stalled.
// Synchronous active-low reset empties the list and clears all credits.
`default_nettype none

module credit_weighted_round_robin_arbiter (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [cwrr_pkg::MODE_W-1:0]       i_mode,
    input  wire [cwrr_pkg::QID_W-1:0]        i_queue_id,
    input  wire                              i_all_blocked,
    input  wire [cwrr_pkg::PEND_W-1:0]       i_pending_q0,
    input  wire [cwrr_pkg::PEND_W-1:0]       i_pending_q1,
    input  wire [cwrr_pkg::PEND_W-1:0]       i_pending_q2,
    input  wire [cwrr_pkg::PEND_W-1:0]       i_pending_q3,
    input  wire [cwrr_pkg::PEND_W-1:0]       i_pending_q4,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_grant_valid,
    output logic [cwrr_pkg::QID_W-1:0]       o_granted_queue,
    output logic [cwrr_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_has_work,
    output logic [cwrr_pkg::CTOTAL_W-1:0]    o_credit_total,
    output logic [cwrr_pkg::MASK_W-1:0]      o_active_mask
);

    cwrr_pkg::t_dp_cmd   w_cmd;
    cwrr_pkg::t_dp_stat  w_stat;
    cwrr_pkg::t_pend_vec w_pend;

    assign w_pend[0] = i_pending_q0;
    assign w_pend[1] = i_pending_q1;
    assign w_pend[2] = i_pending_q2;
    assign w_pend[3] = i_pending_q3;
    assign w_pend[4] = i_pending_q4;

    cwrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cwrr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_mode          (i_mode),
        .i_queue_id      (i_queue_id),
        .i_all_blocked   (i_all_blocked),
        .i_pend          (w_pend),
        .o_grant_valid   (o_grant_valid),
        .o_granted_queue (o_granted_queue),
        .o_status        (o_status),
        .o_has_work      (o_has_work),
        .o_credit_total  (o_credit_total),
        .o_active_mask   (o_active_mask)
    );

endmodule

`default_nettype wire

// ----- design/cwrr_ctrl.sv -----
// Sequencer of the arbiter: accept, execute, per-queue recompute, result hand-off
`default_nettype none

module cwrr_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire                 i_out_stall,
    output logic                o_out_valid,
    input  cwrr_pkg::t_dp_stat  i_stat,
    output cwrr_pkg::t_dp_cmd   o_cmd
);

    cwrr_pkg::t_state              r_state, n_state;
    logic [cwrr_pkg::IDX_W-1:0]    r_q, n_q;
    logic                          r_out_valid, n_out_valid;
    logic                          w_out_free;
    logic                          w_last_q;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_q   = (r_q == cwrr_pkg::IDX_W'(cwrr_pkg::NUM_QUEUES - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            cwrr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = cwrr_pkg::S_EXEC;
            end
            cwrr_pkg::S_EXEC: begin
                n_state = i_stat.need_recomp ? cwrr_pkg::S_RECOMP : cwrr_pkg::S_DONE;
            end
            cwrr_pkg::S_RECOMP: begin
                if (w_last_q) n_state = cwrr_pkg::S_DONE;
            end
            cwrr_pkg::S_DONE: begin
                if (w_out_free) n_state = cwrr_pkg::S_IDLE;
            end
            default: n_state = cwrr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_q         = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            cwrr_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            cwrr_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            cwrr_pkg::S_RECOMP: begin
                o_cmd.recomp_step = 1'b1;
                o_cmd.recomp_q    = r_q;
                n_q               = r_q + cwrr_pkg::IDX_W'(1);
            end
            cwrr_pkg::S_DONE: begin
                o_cmd.out_load = w_out_free;
                if (w_out_free) n_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwrr_pkg::S_IDLE;
            r_q         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_q         <= n_q;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- design/cwrr_dp.sv -----
// Arbiter datapath: service list, credits, active flags, total and result registers
`default_nettype none

`include "credit_weighted_round_robin_arbiter_assert.svh"

module cwrr_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  cwrr_pkg::t_dp_cmd                i_cmd,
    output cwrr_pkg::t_dp_stat               o_stat,
    input  wire [cwrr_pkg::MODE_W-1:0]       i_mode,
    input  wire [cwrr_pkg::QID_W-1:0]        i_queue_id,
    input  wire                              i_all_blocked,
    input  cwrr_pkg::t_pend_vec              i_pend,
    output logic                             o_grant_valid,
    output logic [cwrr_pkg::QID_W-1:0]       o_granted_queue,
    output logic [cwrr_pkg::STATUS_W-1:0]    o_status,
    output logic                             o_has_work,
    output logic [cwrr_pkg::CTOTAL_W-1:0]    o_credit_total,
    output logic [cwrr_pkg::MASK_W-1:0]      o_active_mask
);

    localparam int N = cwrr_pkg::NUM_QUEUES;

    // captured beat
    cwrr_pkg::t_mode                    r_mode;
    logic [cwrr_pkg::QID_W-1:0]         r_qid;
    logic                               r_blocked;
    cwrr_pkg::t_pend_vec                r_pend;

    // arbitration state
    logic [cwrr_pkg::IDX_W-1:0]         r_order   [N];
    logic [cwrr_pkg::IDX_W-1:0]         n_order   [N];
    logic [cwrr_pkg::CREDIT_W-1:0]      r_credits [N];
    logic [cwrr_pkg::CREDIT_W-1:0]      n_credits [N];
    logic [cwrr_pkg::LEN_W-1:0]         r_len, n_len;
    logic [N-1:0]                       r_active, n_active;
    logic [cwrr_pkg::SUM_W-1:0]         r_total, n_total;

    // per-beat result
    logic                               r_grant, n_grant;
    logic [cwrr_pkg::QID_W-1:0]         r_gq, n_gq;
    cwrr_pkg::t_status                  r_status, n_status;

    logic [cwrr_pkg::PEND_W-1:0]        w_pend;
    logic [cwrr_pkg::PSUM_W-1:0]        w_psum;
    logic [cwrr_pkg::CREDIT_W-1:0]      w_cr;
    logic [N-1:0]                       w_drop;
    logic [cwrr_pkg::CREDIT_W-1:0]      w_drop_credit;
    logic [cwrr_pkg::IDX_W-1:0]         w_front;
    logic [cwrr_pkg::CREDIT_W-1:0]      w_front_credit;
    logic [cwrr_pkg::LEN_W-1:0]         w_len_m1;
    logic [cwrr_pkg::SUM_W-1:0]         w_base;
    logic                               w_grant;
    logic                               w_sel_grant;
    logic [cwrr_pkg::SUM_W-1:0]         w_credit_sum;
    logic                               w_stray_credit;
    logic [cwrr_pkg::MASK_W-1:0]        w_mask;

    assign o_stat.need_recomp =
        (r_mode == cwrr_pkg::MODE_MARK_ACTIVE && r_total == '0) ||
        (r_mode == cwrr_pkg::MODE_UPDATE && (r_blocked || r_total == '0));

    // credits of the queue under recompute: ceil(pending / divisor)
    always_comb begin
        w_pend = '0;
        for (int i = 0; i < cwrr_pkg::PEND_INPUTS; i++) begin
            if (int'(i_cmd.recomp_q) == i) w_pend = r_pend[i];
        end
    end
    assign w_psum = {1'b0, w_pend} + cwrr_pkg::PSUM_W'(cwrr_pkg::WEIGHT_DIVISOR - 1);
    assign w_cr   = cwrr_pkg::CREDIT_W'(w_psum / cwrr_pkg::WEIGHT_DIVISOR);

    always_comb begin
        w_drop        = '0;
        w_drop_credit = '0;
        for (int i = 0; i < N; i++) begin
            if (i_cmd.exec && r_mode == cwrr_pkg::MODE_MARK_INACTIVE && int'(r_qid) == i)
                w_drop[i] = r_active[i];
            if (i_cmd.exec && r_mode == cwrr_pkg::MODE_UPDATE && r_credits[i] == '0)
                w_drop[i] = r_active[i];
            if (i_cmd.recomp_step && int'(i_cmd.recomp_q) == i && w_cr == '0)
                w_drop[i] = r_active[i];
            if (w_drop[i]) w_drop_credit = w_drop_credit | r_credits[i];
        end
    end

    assign w_front        = r_order[0];
    assign w_front_credit = r_credits[w_front];
    assign w_len_m1       = r_len - cwrr_pkg::LEN_W'(1);
    assign w_base         = (i_cmd.recomp_q == '0) ? '0 : r_total;
    assign w_grant        = (r_total != '0) && (r_len != '0) && (w_front_credit != '0);
    assign w_sel_grant    = i_cmd.exec && (r_mode == cwrr_pkg::MODE_SELECT) && w_grant;

    always_comb begin
        logic [cwrr_pkg::LEN_W-1:0] ptr;
        ptr       = '0;
        n_order   = r_order;
        n_credits = r_credits;
        n_len     = r_len;
        n_active  = r_active;
        n_total   = r_total;
        n_grant   = r_grant;
        n_gq      = r_gq;
        n_status  = r_status;

        if (|w_drop) begin
            for (int i = 0; i < N; i++) begin
                if (w_drop[i]) begin
                    n_credits[i] = '0;
                    n_active[i]  = 1'b0;
                end
            end
            n_total = r_total - cwrr_pkg::SUM_W'(w_drop_credit);
            for (int k = 0; k < N; k++) begin
                if (cwrr_pkg::LEN_W'(k) < r_len && !w_drop[r_order[k]]) begin
                    n_order[ptr[cwrr_pkg::IDX_W-1:0]] = r_order[k];
                    ptr = ptr + cwrr_pkg::LEN_W'(1);
                end
            end
            n_len = ptr;
        end

        if (i_cmd.exec) begin
            n_grant  = 1'b0;
            n_gq     = '0;
            n_status = cwrr_pkg::ST_OK;
            if (r_mode == cwrr_pkg::MODE_SELECT) begin
                if (r_total == '0) begin
                    n_status = cwrr_pkg::ST_NO_CREDIT;
                end else if (r_len == '0) begin
                    n_status = cwrr_pkg::ST_NO_ACTIVE;
                end else if (w_front_credit != '0) begin
                    n_grant            = 1'b1;
                    n_gq               = cwrr_pkg::QID_W'(w_front);
                    n_total            = r_total - cwrr_pkg::SUM_W'(1);
                    n_credits[w_front] = w_front_credit - cwrr_pkg::CREDIT_W'(1);
                    for (int i = 1; i < N; i++) begin
                        if (cwrr_pkg::LEN_W'(i) < r_len) n_order[i-1] = r_order[i];
                    end
                    n_order[w_len_m1[cwrr_pkg::IDX_W-1:0]] = w_front;
                end else begin
                    n_status = cwrr_pkg::ST_FRONT_EMPTY;
                end
            end
        end

        if (i_cmd.recomp_step) begin
            n_total = w_base + cwrr_pkg::SUM_W'(w_cr);
            if (w_cr != '0) begin
                n_credits[i_cmd.recomp_q] = w_cr;
                if (!r_active[i_cmd.recomp_q]) begin
                    n_active[i_cmd.recomp_q]               = 1'b1;
                    n_order[r_len[cwrr_pkg::IDX_W-1:0]]    = i_cmd.recomp_q;
                    n_len                                  = r_len + cwrr_pkg::LEN_W'(1);
                end
            end
        end
    end

    always_comb begin
        w_mask = '0;
        for (int i = 0; i < cwrr_pkg::MASK_W && i < N; i++) w_mask[i] = r_active[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_active <= '0;
            r_total  <= '0;
            for (int i = 0; i < N; i++) r_credits[i] <= '0;
        end else begin
            r_len     <= n_len;
            r_active  <= n_active;
            r_total   <= n_total;
            r_credits <= n_credits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_order  <= n_order;
        r_grant  <= n_grant;
        r_gq     <= n_gq;
        r_status <= n_status;
        if (i_cmd.load) begin
            r_mode    <= cwrr_pkg::t_mode'(i_mode);
            r_qid     <= i_queue_id;
            r_blocked <= i_all_blocked;
            r_pend    <= i_pend;
        end
        if (i_cmd.out_load) begin
            o_grant_valid   <= r_grant;
            o_granted_queue <= r_gq;
            o_status        <= r_status;
            o_has_work      <= (r_total != '0);
            o_credit_total  <= (r_total > cwrr_pkg::SUM_W'(cwrr_pkg::CTOTAL_MAX)) ?
                               cwrr_pkg::CTOTAL_W'(cwrr_pkg::CTOTAL_MAX) :
                               cwrr_pkg::CTOTAL_W'(r_total);
            o_active_mask   <= w_mask;
        end
    end

    // checks; mid-recompute the total holds only the queues already walked
    always_comb begin
        w_credit_sum   = '0;
        w_stray_credit = 1'b0;
        for (int i = 0; i < N; i++) begin
            w_credit_sum = w_credit_sum + cwrr_pkg::SUM_W'(r_credits[i]);
            if (!r_active[i] && r_credits[i] != '0) w_stray_credit = 1'b1;
        end
    end

    `CWRR_ASSERT_ALWAYS(a_total_is_sum, i_cmd.recomp_step || (r_total == w_credit_sum))
    `CWRR_ASSERT_ALWAYS(a_len_is_active_count, $countones(r_active) == int'(r_len))
    `CWRR_ASSERT_ALWAYS(a_no_idle_credit, !w_stray_credit)
    `CWRR_ASSERT_NEXT(a_grant_spends_one, w_sel_grant, r_total == $past(r_total) - 13'd1)

endmodule

`default_nettype wire
